// ----- design/srcomp_pkg.sv -----
package srcomp_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_TEMP_CAL    = 3'd0;
    localparam logic [2:0] REG_PRESS_CAL_A = 3'd1;
    localparam logic [2:0] REG_PRESS_CAL_B = 3'd2;
    localparam logic [2:0] REG_PRESS_CAL_C = 3'd3;
    localparam logic [2:0] REG_HUM_CAL     = 3'd4;

    // one quotient bit per divider stage
    localparam int DIV_STEPS = 64;

    // humidity ceiling of 100 %RH in Q22.22
    localparam logic signed [63:0] HUM_MAX_Q22 = 64'sd419430400;

    // results that ride along with the pressure divide
    typedef struct packed {
        logic signed [31:0] tc;
        logic signed [31:0] tf;
        logic        [16:0] hum;
    } t_side;

    // partial products of a 64 x 17 product mod 2^64
    typedef struct packed {
        logic signed [49:0] lo;
        logic        [31:0] hi;
    } t_pp;

    // partial products of a 64 x 64 product mod 2^64
    typedef struct packed {
        logic [63:0] ll;
        logic [31:0] c1;
        logic [31:0] c2;
    } t_pp3;

    function automatic t_pp mul_pp(input logic signed [63:0] x, input logic signed [16:0] c);
        t_pp                r;
        logic signed [48:0] h;
        r.lo = $signed({1'b0, x[31:0]}) * c;
        h    = $signed(x[63:32]) * c;
        r.hi = h[31:0];
        return r;
    endfunction

    function automatic logic signed [63:0] pp_sum(input t_pp p);
        return 64'(p.lo) + $signed({p.hi, 32'b0});
    endfunction

    function automatic t_pp3 mul_full(input logic signed [63:0] x, input logic signed [63:0] y);
        t_pp3        r;
        logic [63:0] c1;
        logic [63:0] c2;
        r.ll = x[31:0] * y[31:0];
        c1   = x[31:0] * y[63:32];
        c2   = x[63:32] * y[31:0];
        r.c1 = c1[31:0];
        r.c2 = c2[31:0];
        return r;
    endfunction

    function automatic logic signed [63:0] pp3_sum(input t_pp3 p);
        return $signed(p.ll + {p.c1 + p.c2, 32'b0});
    endfunction

endpackage

// ----- design/srcomp_div.sv -----
module srcomp_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic signed [63:0]    i_num,
    input  logic signed [30:0]    i_den,
    input  srcomp_pkg::t_side     i_side,
    output logic                  o_vld,
    output logic signed [63:0]    o_quo,
    output logic                  o_ok,
    output srcomp_pkg::t_side     o_side
);

    localparam int N = srcomp_pkg::DIV_STEPS;

    logic [63:0]       r_w    [0:N];
    logic [30:0]       r_rem  [0:N];
    logic [30:0]       r_mb   [0:N];
    logic              r_neg  [0:N];
    srcomp_pkg::t_side r_side [0:N];
    logic [N:0]        r_vld;

    // magnitudes and result sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w[0]    <= i_num[63] ? $unsigned(-i_num) : $unsigned(i_num);
            r_mb[0]   <= i_den[30] ? $unsigned(-i_den) : $unsigned(i_den);
            r_rem[0]  <= '0;
            r_neg[0]  <= i_num[63] ^ i_den[30];
            r_side[0] <= i_side;
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar i = 1; i <= N; i++) begin : g_step
        logic [31:0] w_t;
        logic        w_ge;
        assign w_t  = {r_rem[i-1], r_w[i-1][63]};
        assign w_ge = w_t >= {1'b0, r_mb[i-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i]  <= w_ge ? 31'(w_t - {1'b0, r_mb[i-1]}) : w_t[30:0];
                r_w[i]    <= {r_w[i-1][62:0], w_ge};
                r_mb[i]   <= r_mb[i-1];
                r_neg[i]  <= r_neg[i-1];
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // signed quotient
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_quo  <= r_neg[N] ? -$signed(r_w[N]) : $signed(r_w[N]);
            o_ok   <= |r_mb[N];
            o_side <= r_side[N];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            o_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-1:0], i_vld};
            o_vld <= r_vld[N];
        end
    end

endmodule

// ----- design/sensor_reading_compensation.sv -----
// channel   | direction | content (lowest bit first)
// s_axis    | in        | raw_temp 20, raw_press 20, raw_hum 16
// m_axis    | out       | temp_centi 32, fine_temp 32, press_q24_8 32, press_valid 1,
//           |           | hum_q22_10 17, zero pad 6
// i_cfg_*   | in        | register index 3, write data 64
//
// one item per cycle while the output is not stalled; 18 stages of polynomial work, 66 in the
// pressure divider (sign stage, 64 quotient stages, output register) and 6 after it
// synchronous active-low reset clears valid bits and calibration registers
// a stalled output freezes the whole pipeline; nothing is dropped or repeated
module sensor_reading_compensation (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [63:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [55:0]  s_axis_tdata,   // raw_temp, raw_press, raw_hum
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata    // temp_centi, fine_temp, press_q24_8,
                                         // press_valid, hum_q22_10, pad
);

    // calibration registers
    logic [47:0] r_temp_cal, r_press_cal_a, r_press_cal_b, r_press_cal_c;
    logic [63:0] r_hum_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_cal    <= '0;
            r_press_cal_a <= '0;
            r_press_cal_b <= '0;
            r_press_cal_c <= '0;
            r_hum_cal     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                srcomp_pkg::REG_TEMP_CAL:    r_temp_cal    <= i_cfg_data[47:0];
                srcomp_pkg::REG_PRESS_CAL_A: r_press_cal_a <= i_cfg_data[47:0];
                srcomp_pkg::REG_PRESS_CAL_B: r_press_cal_b <= i_cfg_data[47:0];
                srcomp_pkg::REG_PRESS_CAL_C: r_press_cal_c <= i_cfg_data[47:0];
                srcomp_pkg::REG_HUM_CAL:     r_hum_cal     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // coefficient fields
    logic        [15:0] w_t1, w_p1;
    logic signed [15:0] w_t2, w_t3, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9, w_h2;
    logic        [7:0]  w_h1, w_h3;
    logic signed [11:0] w_h4, w_h5;
    logic signed [7:0]  w_h6;

    assign w_t1 = r_temp_cal[15:0];
    assign w_t2 = $signed(r_temp_cal[31:16]);
    assign w_t3 = $signed(r_temp_cal[47:32]);
    assign w_p1 = r_press_cal_a[15:0];
    assign w_p2 = $signed(r_press_cal_a[31:16]);
    assign w_p3 = $signed(r_press_cal_a[47:32]);
    assign w_p4 = $signed(r_press_cal_b[15:0]);
    assign w_p5 = $signed(r_press_cal_b[31:16]);
    assign w_p6 = $signed(r_press_cal_b[47:32]);
    assign w_p7 = $signed(r_press_cal_c[15:0]);
    assign w_p8 = $signed(r_press_cal_c[31:16]);
    assign w_p9 = $signed(r_press_cal_c[47:32]);
    assign w_h1 = r_hum_cal[7:0];
    assign w_h2 = $signed(r_hum_cal[23:8]);
    assign w_h3 = r_hum_cal[31:24];
    assign w_h4 = $signed(r_hum_cal[43:32]);
    assign w_h5 = $signed(r_hum_cal[55:44]);
    assign w_h6 = $signed(r_hum_cal[63:56]);

    // pipeline advance
    logic       w_en;
    logic [18:1] r_kv;
    logic [6:1]  r_pv;

    assign w_en          = !r_pv[6] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_pv[6];

    logic [19:0] w_raw_temp, w_raw_press;
    logic [15:0] w_raw_hum;
    assign w_raw_temp  = s_axis_tdata[19:0];
    assign w_raw_press = s_axis_tdata[39:20];
    assign w_raw_hum   = s_axis_tdata[55:40];

    // stage registers, front half
    logic signed [17:0] r_k1_ta;
    logic signed [16:0] r_k1_tb;
    logic [19:0] r_k1_ap, r_k2_ap, r_k3_ap, r_k4_ap, r_k5_ap, r_k6_ap;
    logic [15:0] r_k1_ah, r_k2_ah, r_k3_ah, r_k4_ah, r_k5_ah;
    logic signed [33:0] r_k2_m1, r_k2_bb;
    logic signed [22:0] r_k3_v1;
    logic signed [37:0] r_k3_m2;
    logic signed [31:0] r_k4_tf;
    logic signed [26:0] r_k5_px, r_k5_hx;
    srcomp_pkg::t_side  r_k5_sd, r_k6_sd, r_k7_sd, r_k8_sd, r_k9_sd, r_k10_sd, r_k11_sd;
    srcomp_pkg::t_side  r_k12_sd, r_k13_sd, r_k14_sd, r_k15_sd, r_k16_sd, r_k17_sd, r_k18_sd;
    logic signed [53:0] r_k6_pxx;
    logic signed [42:0] r_k6_pp5, r_k6_pp2, r_k7_pp5, r_k7_pp2, r_k8_pp5, r_k8_pp2;
    logic signed [33:0] r_k6_hpre;
    logic signed [38:0] r_k6_h5x;
    logic signed [34:0] r_k6_xh6;
    logic signed [35:0] r_k6_xh3;
    srcomp_pkg::t_pp    r_k7_pp6, r_k7_pp3, r_k11_pq, r_k11_pn, r_k16_pt;
    logic signed [63:0] r_k7_num0, r_k8_num0, r_k9_num0;
    logic signed [24:0] r_k7_ah, r_k8_ah, r_k9_ah, r_k10_ah, r_k11_ah;
    logic signed [24:0] r_k7_t6;
    logic signed [25:0] r_k7_t3;
    logic signed [63:0] r_k8_pp6, r_k8_pp3;
    logic signed [50:0] r_k8_m;
    logic signed [63:0] r_k9_v2, r_k9_v1;
    logic signed [41:0] r_k9_b;
    logic signed [63:0] r_k10_q, r_k10_n;
    logic signed [57:0] r_k10_b2;
    logic signed [43:0] r_k11_bb;
    logic signed [63:0] r_k12_prod, r_k12_num;
    srcomp_pkg::t_pp3   r_k12_px, r_k14_pa;
    logic signed [30:0] r_k13_d, r_k14_d, r_k15_d, r_k16_d, r_k17_d, r_k18_d;
    logic signed [63:0] r_k13_num, r_k14_num, r_k15_num, r_k16_num, r_k17_num, r_k18_num;
    logic signed [63:0] r_k13_xh, r_k14_xh, r_k15_xh, r_k16_xh, r_k17_xh;
    logic signed [63:0] r_k15_aa, r_k17_t;

    // combinational helpers needing part-selects
    logic signed [34:0] w_tc5;
    logic        [20:0] w_pdiff;
    logic signed [39:0] w_hd;
    logic signed [57:0] w_b2r;
    logic signed [63:0] w_a2, w_hx;
    logic        [28:0] w_hc;

    assign w_tc5   = 35'(r_k4_tf) * 35'sd5 + 35'sd128;
    assign w_pdiff = 21'd1048576 - {1'b0, r_k6_ap};
    assign w_hd    = 40'(r_k6_hpre) - 40'(r_k6_h5x);
    assign w_b2r   = r_k10_b2 + 58'sd8192;
    assign w_a2    = 64'($signed(r_k13_xh[63:15]));
    assign w_hx    = r_k17_xh - 64'($signed(r_k17_t[63:4]));

    // humidity clamp to 0..100 %RH
    always_comb begin
        if (w_hx < 0) begin
            w_hc = '0;
        end else if (w_hx > srcomp_pkg::HUM_MAX_Q22) begin
            w_hc = 29'(srcomp_pkg::HUM_MAX_Q22);
        end else begin
            w_hc = w_hx[28:0];
        end
    end

    // temperature, then pressure and humidity polynomials up to the divide
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // differences against t1
            r_k1_ta <= $signed({1'b0, w_raw_temp[19:3]}) - $signed({1'b0, w_t1, 1'b0});
            r_k1_tb <= $signed({1'b0, w_raw_temp[19:4]}) - $signed({1'b0, w_t1});
            r_k1_ap <= w_raw_press;
            r_k1_ah <= w_raw_hum;
            // temperature products
            r_k2_m1 <= r_k1_ta * w_t2;
            r_k2_bb <= r_k1_tb * r_k1_tb;
            r_k2_ap <= r_k1_ap;
            r_k2_ah <= r_k1_ah;
            r_k3_v1 <= $signed(r_k2_m1[33:11]);
            r_k3_m2 <= $signed(r_k2_bb[33:12]) * w_t3;
            r_k3_ap <= r_k2_ap;
            r_k3_ah <= r_k2_ah;
            // fine temperature
            r_k4_tf <= 32'(r_k3_v1) + 32'($signed(r_k3_m2[37:14]));
            r_k4_ap <= r_k3_ap;
            r_k4_ah <= r_k3_ah;
            // centi degrees and offsets for pressure and humidity
            r_k5_sd.tc  <= 32'($signed(w_tc5[34:8]));
            r_k5_sd.tf  <= r_k4_tf;
            r_k5_sd.hum <= '0;
            r_k5_px <= 27'(r_k4_tf) - 27'sd128000;
            r_k5_hx <= 27'(r_k4_tf) - 27'sd76800;
            r_k5_ap <= r_k4_ap;
            r_k5_ah <= r_k4_ah;
            // first products of both branches
            r_k6_pxx  <= r_k5_px * r_k5_px;
            r_k6_pp5  <= r_k5_px * w_p5;
            r_k6_pp2  <= r_k5_px * w_p2;
            r_k6_ap   <= r_k5_ap;
            r_k6_hpre <= $signed({4'b0, r_k5_ah, 14'b0})
                         - $signed({{2{w_h4[11]}}, w_h4, 20'b0}) + 34'sd16384;
            r_k6_h5x  <= w_h5 * r_k5_hx;
            r_k6_xh6  <= r_k5_hx * w_h6;
            r_k6_xh3  <= r_k5_hx * $signed({1'b0, w_h3});
            r_k6_sd   <= r_k5_sd;
            // wide pressure products split in halves
            r_k7_pp6  <= srcomp_pkg::mul_pp(64'(r_k6_pxx), 17'(w_p6));
            r_k7_pp3  <= srcomp_pkg::mul_pp(64'(r_k6_pxx), 17'(w_p3));
            r_k7_pp5  <= r_k6_pp5;
            r_k7_pp2  <= r_k6_pp2;
            r_k7_num0 <= $signed({12'b0, w_pdiff, 31'b0});
            r_k7_ah   <= $signed(w_hd[39:15]);
            r_k7_t6   <= $signed(r_k6_xh6[34:10]);
            r_k7_t3   <= 26'($signed(r_k6_xh3[35:11])) + 26'sd32768;
            r_k7_sd   <= r_k6_sd;
            r_k8_pp6  <= srcomp_pkg::pp_sum(r_k7_pp6);
            r_k8_pp3  <= srcomp_pkg::pp_sum(r_k7_pp3);
            r_k8_pp5  <= r_k7_pp5;
            r_k8_pp2  <= r_k7_pp2;
            r_k8_num0 <= r_k7_num0;
            r_k8_m    <= r_k7_t6 * r_k7_t3;
            r_k8_ah   <= r_k7_ah;
            r_k8_sd   <= r_k7_sd;
            // pressure var1 and var2 sums
            r_k9_v2   <= r_k8_pp6 + $signed({{4{r_k8_pp5[42]}}, r_k8_pp5, 17'b0})
                         + $signed({{13{w_p4[15]}}, w_p4, 35'b0});
            r_k9_v1   <= 64'($signed(r_k8_pp3[63:8]))
                         + $signed({{9{r_k8_pp2[42]}}, r_k8_pp2, 12'b0});
            r_k9_num0 <= r_k8_num0;
            r_k9_b    <= 42'($signed(r_k8_m[50:10])) + 42'sd2097152;
            r_k9_ah   <= r_k8_ah;
            r_k9_sd   <= r_k8_sd;
            r_k10_q   <= r_k9_v1 + 64'sh0000_8000_0000_0000;
            r_k10_n   <= r_k9_num0 - r_k9_v2;
            r_k10_b2  <= r_k9_b * w_h2;
            r_k10_ah  <= r_k9_ah;
            r_k10_sd  <= r_k9_sd;
            // divisor and dividend products
            r_k11_pq  <= srcomp_pkg::mul_pp(r_k10_q, $signed({1'b0, w_p1}));
            r_k11_pn  <= srcomp_pkg::mul_pp(r_k10_n, 17'sd3125);
            r_k11_bb  <= $signed(w_b2r[57:14]);
            r_k11_ah  <= r_k10_ah;
            r_k11_sd  <= r_k10_sd;
            r_k12_prod <= srcomp_pkg::pp_sum(r_k11_pq);
            r_k12_num  <= srcomp_pkg::pp_sum(r_k11_pn);
            r_k12_px   <= srcomp_pkg::mul_full(64'(r_k11_ah), 64'(r_k11_bb));
            r_k12_sd   <= r_k11_sd;
            r_k13_d    <= $signed(r_k12_prod[63:33]);
            r_k13_num  <= r_k12_num;
            r_k13_xh   <= srcomp_pkg::pp3_sum(r_k12_px);
            r_k13_sd   <= r_k12_sd;
            // humidity correction term
            r_k14_pa   <= srcomp_pkg::mul_full(w_a2, w_a2);
            r_k14_xh   <= r_k13_xh;
            r_k14_d    <= r_k13_d;
            r_k14_num  <= r_k13_num;
            r_k14_sd   <= r_k13_sd;
            r_k15_aa   <= srcomp_pkg::pp3_sum(r_k14_pa);
            r_k15_xh   <= r_k14_xh;
            r_k15_d    <= r_k14_d;
            r_k15_num  <= r_k14_num;
            r_k15_sd   <= r_k14_sd;
            r_k16_pt   <= srcomp_pkg::mul_pp(64'($signed(r_k15_aa[63:7])),
                                             $signed({9'b0, w_h1}));
            r_k16_xh   <= r_k15_xh;
            r_k16_d    <= r_k15_d;
            r_k16_num  <= r_k15_num;
            r_k16_sd   <= r_k15_sd;
            r_k17_t    <= srcomp_pkg::pp_sum(r_k16_pt);
            r_k17_xh   <= r_k16_xh;
            r_k17_d    <= r_k16_d;
            r_k17_num  <= r_k16_num;
            r_k17_sd   <= r_k16_sd;
            // clamped humidity joins the side results
            r_k18_sd.tc  <= r_k17_sd.tc;
            r_k18_sd.tf  <= r_k17_sd.tf;
            r_k18_sd.hum <= w_hc[28:12];
            r_k18_d      <= r_k17_d;
            r_k18_num    <= r_k17_num;
        end
    end

    // pressure divide
    logic               w_dv_vld;
    logic signed [63:0] w_dv_quo;
    logic               w_dv_ok;
    srcomp_pkg::t_side  w_dv_side;

    srcomp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_kv[18]),
        .i_num   (r_k18_num),
        .i_den   (r_k18_d),
        .i_side  (r_k18_sd),
        .o_vld   (w_dv_vld),
        .o_quo   (w_dv_quo),
        .o_ok    (w_dv_ok),
        .o_side  (w_dv_side)
    );

    // back half: p8 and p9 terms
    logic signed [63:0] w_pa, w_pr;
    logic signed [63:0] r_p1_p, r_p1_a, r_p2_p, r_p2_a, r_p3_p, r_p4_p;
    srcomp_pkg::t_pp    r_p1_pp8, r_p1_pa9;
    logic signed [63:0] r_p2_pp8, r_p2_pa9, r_p3_v2, r_p4_v2, r_p4_pa9a, r_p5_s;
    srcomp_pkg::t_pp3   r_p3_pf;
    logic               r_p1_ok, r_p2_ok, r_p3_ok, r_p4_ok, r_p5_ok, r_out_ok;
    srcomp_pkg::t_side  r_p1_sd, r_p2_sd, r_p3_sd, r_p4_sd, r_p5_sd, r_out_sd;
    logic [31:0]        r_out_press;

    assign w_pa = 64'($signed(w_dv_quo[63:13]));
    assign w_pr = 64'($signed(r_p5_s[63:8])) + $signed({{44{w_p7[15]}}, w_p7, 4'b0});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_p    <= w_dv_quo;
            r_p1_a    <= w_pa;
            r_p1_pp8  <= srcomp_pkg::mul_pp(w_dv_quo, 17'(w_p8));
            r_p1_pa9  <= srcomp_pkg::mul_pp(w_pa, 17'(w_p9));
            r_p1_ok   <= w_dv_ok;
            r_p1_sd   <= w_dv_side;
            r_p2_pp8  <= srcomp_pkg::pp_sum(r_p1_pp8);
            r_p2_pa9  <= srcomp_pkg::pp_sum(r_p1_pa9);
            r_p2_p    <= r_p1_p;
            r_p2_a    <= r_p1_a;
            r_p2_ok   <= r_p1_ok;
            r_p2_sd   <= r_p1_sd;
            r_p3_pf   <= srcomp_pkg::mul_full(r_p2_pa9, r_p2_a);
            r_p3_v2   <= 64'($signed(r_p2_pp8[63:19]));
            r_p3_p    <= r_p2_p;
            r_p3_ok   <= r_p2_ok;
            r_p3_sd   <= r_p2_sd;
            r_p4_pa9a <= srcomp_pkg::pp3_sum(r_p3_pf);
            r_p4_v2   <= r_p3_v2;
            r_p4_p    <= r_p3_p;
            r_p4_ok   <= r_p3_ok;
            r_p4_sd   <= r_p3_sd;
            r_p5_s    <= r_p4_p + 64'($signed(r_p4_pa9a[63:25])) + r_p4_v2;
            r_p5_ok   <= r_p4_ok;
            r_p5_sd   <= r_p4_sd;
            // output register
            r_out_press <= r_p5_ok ? w_pr[31:0] : '0;
            r_out_ok    <= r_p5_ok;
            r_out_sd    <= r_p5_sd;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kv <= '0;
            r_pv <= '0;
        end else if (w_en) begin
            r_kv <= {r_kv[17:1], s_axis_tvalid};
            r_pv <= {r_pv[5:1], w_dv_vld};
        end
    end

    assign m_axis_tdata = {6'b0, r_out_sd.hum, r_out_ok, r_out_press,
                           r_out_sd.tf, r_out_sd.tc};

    // checks
    logic signed [34:0] w_chk_tc5;
    assign w_chk_tc5 = 35'($signed(m_axis_tdata[63:32])) * 35'sd5 + 35'sd128;

    a_tc_matches_tf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $signed(m_axis_tdata[31:0]) == 32'($signed(w_chk_tc5[34:8])))
        else $error("temp_centi does not follow fine_temp");

    a_press_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[96] |-> m_axis_tdata[95:64] == 32'd0)
        else $error("pressure not cleared on zero divisor");

    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[113:97] <= 17'd102400)
        else $error("humidity above 100 percent");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output slot");

endmodule
